>>> design/pcrp_pkg.sv
// ---------------------------------------------------------------------------
// pcrp_pkg: shared types and constants of the PCM codec playback block
// Request and result payloads, port and register codes, the reset image of
// the indexed register file and the attenuation table.
// ---------------------------------------------------------------------------
package pcrp_pkg;

    localparam int REG_COUNT    = 16;
    localparam int GAIN_ENTRIES = 64;
    localparam int IDX_W        = $clog2(REG_COUNT);
    localparam int GAIN_IDX_W   = $clog2(GAIN_ENTRIES);
    localparam int GAIN_W       = 17;
    localparam int SAMPLE_W     = 16;
    localparam int COUNT_W      = 17;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        PORT_INDEX  = 2'd0,
        PORT_DATA   = 2'd1,
        PORT_STATUS = 2'd2,
        PORT_UNUSED = 2'd3
    } t_port;

    // Register indexes with special meaning.
    localparam logic [IDX_W-1:0] REG_LEFT_CTRL  = 4'd6;
    localparam logic [IDX_W-1:0] REG_RIGHT_CTRL = 4'd7;
    localparam logic [IDX_W-1:0] REG_FORMAT     = 4'd8;
    localparam logic [IDX_W-1:0] REG_PLAY_CFG   = 4'd9;
    localparam logic [IDX_W-1:0] REG_PIN_CTRL   = 4'd10;
    localparam logic [IDX_W-1:0] REG_READ_ONLY  = 4'd12;
    localparam logic [IDX_W-1:0] REG_COUNT_HI   = 4'd14;
    localparam logic [IDX_W-1:0] REG_COUNT_LO   = 4'd15;

    // Sample format codes, taken from format register bits 6:4.
    localparam logic [2:0] FMT_MONO8    = 3'b000;
    localparam logic [2:0] FMT_STEREO8  = 3'b001;
    localparam logic [2:0] FMT_MONO16   = 3'b100;
    localparam logic [2:0] FMT_STEREO16 = 3'b101;

    localparam logic [7:0] STATUS_BASE  = 8'hcc;
    localparam logic [7:0] PLAY_MASK    = 8'h41;
    localparam logic [7:0] PLAY_ON      = 8'h01;
    localparam logic [7:0] IDLE_READ    = 8'hff;

    typedef struct packed {
        logic [1:0]  operation;
        logic [1:0]  bus_address;
        logic [7:0]  write_data;
        logic [31:0] dma_bytes;
    } t_in_item;

    typedef struct packed {
        logic [7:0]                 read_data;
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
        logic [2:0]                 bytes_taken;
        logic                       irq_pulse;
    } t_out_item;

    function automatic logic [7:0] reg_reset_value(input logic [IDX_W-1:0] idx);
        logic [7:0] v;
        unique case (idx)
            4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7: v = 8'h80;
            4'd9:                               v = 8'h08;
            4'd12:                              v = 8'h0a;
            default:                            v = 8'h00;
        endcase
        return v;
    endfunction

    // Amplitude gain in 1.5 dB steps, scaled by 65536.
    function automatic logic [GAIN_W-1:0] gain_lookup(input logic [GAIN_IDX_W-1:0] k);
        logic [GAIN_W-1:0] g;
        unique case (k)
            6'd0:  g = 17'd65536; 6'd1:  g = 17'd55141; 6'd2:  g = 17'd46395;
            6'd3:  g = 17'd39037; 6'd4:  g = 17'd32845; 6'd5:  g = 17'd27636;
            6'd6:  g = 17'd23253; 6'd7:  g = 17'd19565; 6'd8:  g = 17'd16461;
            6'd9:  g = 17'd13850; 6'd10: g = 17'd11654; 6'd11: g = 17'd9805;
            6'd12: g = 17'd8250;  6'd13: g = 17'd6941;  6'd14: g = 17'd5840;
            6'd15: g = 17'd4914;  6'd16: g = 17'd4135;  6'd17: g = 17'd3479;
            6'd18: g = 17'd2927;  6'd19: g = 17'd2463;  6'd20: g = 17'd2072;
            6'd21: g = 17'd1743;  6'd22: g = 17'd1467;  6'd23: g = 17'd1234;
            6'd24: g = 17'd1038;  6'd25: g = 17'd873;   6'd26: g = 17'd735;
            6'd27: g = 17'd618;   6'd28: g = 17'd520;   6'd29: g = 17'd438;
            6'd30: g = 17'd368;   6'd31: g = 17'd310;   6'd32: g = 17'd260;
            6'd33: g = 17'd219;   6'd34: g = 17'd184;   6'd35: g = 17'd155;
            6'd36: g = 17'd130;   6'd37: g = 17'd110;   6'd38: g = 17'd92;
            6'd39: g = 17'd77;    6'd40: g = 17'd65;    6'd41: g = 17'd55;
            6'd42: g = 17'd46;    6'd43: g = 17'd39;    6'd44: g = 17'd32;
            6'd45: g = 17'd27;    6'd46: g = 17'd23;    6'd47: g = 17'd19;
            6'd48: g = 17'd16;    6'd49: g = 17'd13;    6'd50: g = 17'd11;
            6'd51: g = 17'd9;     6'd52: g = 17'd8;     6'd53: g = 17'd6;
            6'd54: g = 17'd5;     6'd55: g = 17'd4;     6'd56: g = 17'd4;
            6'd57: g = 17'd3;     6'd58: g = 17'd2;     6'd59: g = 17'd2;
            6'd60: g = 17'd2;     6'd61: g = 17'd1;     6'd62: g = 17'd1;
            default: g = 17'd1;
        endcase
        return g;
    endfunction

endpackage

>>> design/pcrp_channels.sv
// ---------------------------------------------------------------------------
// pcrp_channels: request and result channels of the playback block
// Valid/ready channels carrying one request or one result per handshake.
// ---------------------------------------------------------------------------
interface pcrp_in_if;
    logic               valid;
    logic               ready;
    pcrp_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pcrp_out_if;
    logic                valid;
    logic                ready;
    pcrp_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/pcm_codec_register_playback.sv
// ---------------------------------------------------------------------------
// pcm_codec_register_playback: playback side of an indexed-register codec
// Bus port decode, indexed register file, PCM unpacking, attenuation and
// the sample countdown with its status flag and interrupt pulse.
// ---------------------------------------------------------------------------
// Each request gives exactly one result. A request is captured in an input
// register, handled by one pass of logic (register file access, sample
// unpacking, one 16 x 17 gain multiply per channel, countdown update) and
// written to a result register, and a new request is taken every cycle as
// long as the result side keeps up. The result register frees as soon as its
// result is taken in the same cycle.
module pcm_codec_register_playback (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pcrp_in_if.sink           i_in,
    pcrp_out_if.source        o_out
);

    localparam int IW = pcrp_pkg::IDX_W;
    localparam int SW = pcrp_pkg::SAMPLE_W;
    localparam int CW = pcrp_pkg::COUNT_W;

    // Pipeline registers.
    logic                 r_in_valid;
    pcrp_pkg::t_in_item   r_in;
    logic                 r_out_valid;
    pcrp_pkg::t_out_item  r_out;
    logic                 advance;

    // Architectural state.
    logic [IW-1:0]        r_index,     n_index;
    logic                 r_trd,       n_trd;
    logic                 r_mce,       n_mce;
    logic [7:0]           r_regs [pcrp_pkg::REG_COUNT];
    logic                 r_status_flag, n_status_flag;
    logic                 r_play_en,   n_play_en;
    logic signed [CW-1:0] r_countdown, n_countdown;
    logic signed [SW-1:0] r_left_hold, n_left_hold;
    logic signed [SW-1:0] r_right_hold, n_right_hold;

    logic                 reg_we;
    logic [7:0]           rd_data;
    logic [2:0]           taken;
    logic                 irq;
    logic signed [SW-1:0] left_raw, right_raw;
    logic signed [SW-1:0] left_att, right_att;
    logic signed [CW-1:0] cd_loaded;
    logic [7:0]           b0, b1, b2, b3;
    pcrp_pkg::t_op        op;
    pcrp_pkg::t_port      port;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign op   = pcrp_pkg::t_op'(r_in.operation);
    assign port = pcrp_pkg::t_port'(r_in.bus_address);
    assign b0   = r_in.dma_bytes[7:0];
    assign b1   = r_in.dma_bytes[15:8];
    assign b2   = r_in.dma_bytes[23:16];
    assign b3   = r_in.dma_bytes[31:24];

    function automatic logic signed [SW-1:0] from_byte8(input logic [7:0] b);
        return {~b[7], b[6:0], 8'h00};
    endfunction

    // Mute, then floor(sample * gain / 65536); the arithmetic shift floors.
    function automatic logic signed [SW-1:0] attenuate(input logic signed [SW-1:0] s,
                                                       input logic [7:0] ctrl);
        logic signed [SW+pcrp_pkg::GAIN_W:0] prod;
        prod = s * $signed({1'b0, pcrp_pkg::gain_lookup(ctrl[5:0])});
        return ctrl[7] ? '0 : prod[SW+15:16];
    endfunction

    // Sample unpacking. Unsupported formats pass the held samples again.
    always_comb begin
        taken     = 3'd0;
        left_raw  = r_left_hold;
        right_raw = r_right_hold;
        unique case (r_regs[pcrp_pkg::REG_FORMAT][6:4])
            pcrp_pkg::FMT_MONO8: begin
                left_raw  = from_byte8(b0);
                right_raw = from_byte8(b0);
                taken     = 3'd1;
            end
            pcrp_pkg::FMT_STEREO8: begin
                left_raw  = from_byte8(b0);
                right_raw = from_byte8(b1);
                taken     = 3'd2;
            end
            pcrp_pkg::FMT_MONO16: begin
                left_raw  = {b1, b0};
                right_raw = {b1, b0};
                taken     = 3'd2;
            end
            pcrp_pkg::FMT_STEREO16: begin
                left_raw  = {b1, b0};
                right_raw = {b3, b2};
                taken     = 3'd4;
            end
            default: ;
        endcase
    end

    assign left_att  = attenuate(left_raw,  r_regs[pcrp_pkg::REG_LEFT_CTRL]);
    assign right_att = attenuate(right_raw, r_regs[pcrp_pkg::REG_RIGHT_CTRL]);
    assign cd_loaded = {1'b0, r_regs[pcrp_pkg::REG_COUNT_HI], r_regs[pcrp_pkg::REG_COUNT_LO]};

    always_comb begin
        n_index       = r_index;
        n_trd         = r_trd;
        n_mce         = r_mce;
        n_status_flag = r_status_flag;
        n_play_en     = r_play_en;
        n_countdown   = r_countdown;
        n_left_hold   = r_left_hold;
        n_right_hold  = r_right_hold;
        reg_we        = 1'b0;
        rd_data       = pcrp_pkg::IDLE_READ;
        irq           = 1'b0;
        unique case (op)
            pcrp_pkg::OP_READ: begin
                unique case (port)
                    pcrp_pkg::PORT_INDEX:  rd_data = {1'b0, r_mce, r_trd, 1'b0, r_index};
                    pcrp_pkg::PORT_DATA:   rd_data = r_regs[r_index];
                    pcrp_pkg::PORT_STATUS: rd_data = pcrp_pkg::STATUS_BASE
                                                     | {7'd0, r_status_flag};
                    default: ;
                endcase
            end
            pcrp_pkg::OP_WRITE: begin
                unique case (port)
                    pcrp_pkg::PORT_INDEX: begin
                        n_index = r_in.write_data[IW-1:0];
                        n_trd   = r_in.write_data[5];
                        n_mce   = r_in.write_data[6];
                    end
                    pcrp_pkg::PORT_DATA: begin
                        reg_we = (r_index != pcrp_pkg::REG_READ_ONLY);
                        if (r_index == pcrp_pkg::REG_PLAY_CFG) begin
                            n_play_en = ((r_in.write_data & pcrp_pkg::PLAY_MASK)
                                         == pcrp_pkg::PLAY_ON);
                            if (!n_play_en) begin
                                n_left_hold  = '0;
                                n_right_hold = '0;
                            end
                        end else if (r_index == pcrp_pkg::REG_COUNT_HI) begin
                            n_countdown = {1'b0, r_in.write_data,
                                           r_regs[pcrp_pkg::REG_COUNT_LO]};
                        end
                    end
                    pcrp_pkg::PORT_STATUS: n_status_flag = 1'b0;
                    default: ;
                endcase
            end
            pcrp_pkg::OP_TICK: begin
                if (r_play_en) begin
                    n_left_hold  = left_att;
                    n_right_hold = right_att;
                    // The countdown only ever reaches -1 before it reloads.
                    if (r_countdown[CW-1]) begin
                        n_countdown = cd_loaded - CW'(1);
                        if (!r_status_flag) begin
                            n_status_flag = 1'b1;
                            irq = r_regs[pcrp_pkg::REG_PIN_CTRL][1];
                        end
                    end else begin
                        n_countdown = r_countdown - CW'(1);
                    end
                end else begin
                    n_left_hold  = '0;
                    n_right_hold = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_index       <= '0;
            r_trd         <= 1'b0;
            r_mce         <= 1'b1;
            r_status_flag <= 1'b0;
            r_play_en     <= 1'b0;
            r_countdown   <= '0;
            r_left_hold   <= '0;
            r_right_hold  <= '0;
            for (int i = 0; i < pcrp_pkg::REG_COUNT; i++) begin
                r_regs[i] <= pcrp_pkg::reg_reset_value(IW'(i));
            end
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid   <= 1'b1;
                r_index       <= n_index;
                r_trd         <= n_trd;
                r_mce         <= n_mce;
                r_status_flag <= n_status_flag;
                r_play_en     <= n_play_en;
                r_countdown   <= n_countdown;
                r_left_hold   <= n_left_hold;
                r_right_hold  <= n_right_hold;
                if (reg_we) begin
                    r_regs[r_index] <= r_in.write_data;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
        if (advance) begin
            r_out.read_data    <= rd_data;
            r_out.left_sample  <= n_left_hold;
            r_out.right_sample <= n_right_hold;
            r_out.bytes_taken  <= (op == pcrp_pkg::OP_TICK && r_play_en) ? taken : 3'd0;
            r_out.irq_pulse    <= irq;
        end
    end

`ifndef SYNTHESIS
    a_irq_sets_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.irq_pulse |-> r_status_flag)
        else $error("interrupt pulse without status flag");

    a_holds_zero_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_play_en |-> (r_left_hold == '0) && (r_right_hold == '0))
        else $error("held samples nonzero while playback is off");

    a_countdown_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_countdown[CW-1] |-> (r_countdown == -CW'(1)))
        else $error("countdown went below minus one");

    a_taken_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot0(r_out.bytes_taken))
        else $error("bytes taken is not 0, 1, 2 or 4");

    a_state_frozen_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> $stable(r_countdown) && $stable(r_status_flag))
        else $error("state changed while the result register was stalled");
`endif

endmodule
